>>> rtl/radix_digit_converter_defines.svh
// Assertion macros used by the radix digit converter RTL.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Checks that cons holds in the same cycle as ante, outside reset.
`define RDC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("radix digit converter: same-cycle check failed");

// Checks that cons holds in the cycle after ante, outside reset.
`define RDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("radix digit converter: next-cycle check failed");

`endif

>>> rtl/rdc_pkg.sv
// Types, constants and the digit glyph function of the radix digit converter.
package rdc_pkg;

  localparam int ValueWidth    = 32;
  localparam int RadixWidth    = 5;
  localparam int CharWidth     = 7;
  localparam int DigitWidth    = 4;
  localparam int DefValueBits  = 32;
  localparam int DefMaxDigits  = 32;

  localparam logic [RadixWidth-1:0] RadixReset = RadixWidth'(10);
  localparam logic [RadixWidth-1:0] RadixMin   = RadixWidth'(2);
  localparam logic [RadixWidth-1:0] RadixMax   = RadixWidth'(16);

  localparam logic [CharWidth-1:0]  CharZero    = CharWidth'(48);
  localparam logic [CharWidth-1:0]  CharAlpha   = CharWidth'(65);
  localparam logic [DigitWidth-1:0] DecimalBase = DigitWidth'(10);

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StEmit
  } state_e;

  // Commands to the serial divider.
  typedef struct packed {
    logic load;   // start on a new dividend
    logic next;   // start again on the quotient just produced
  } div_ctrl_t;

  // Status from the serial divider, valid in the cycle done is high.
  typedef struct packed {
    logic                  done;
    logic                  nonzero;
    logic [DigitWidth-1:0] rem;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic logic [CharWidth-1:0] digit_to_char(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] c;
    if (d < DecimalBase) begin
      c = CharZero + CharWidth'(d);
    end else begin
      c = CharAlpha + CharWidth'(d - DecimalBase);
    end
    return c;
  endfunction

endpackage

>>> rtl/rdc_value_if.sv
// Input channel carrying the value to convert.
interface rdc_value_if;
  logic                             valid;
  logic                             ready;
  logic [rdc_pkg::ValueWidth-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/rdc_digit_if.sv
// Output channel carrying one ASCII digit per beat.
interface rdc_digit_if;
  logic                            valid;
  logic                            ready;
  logic [rdc_pkg::CharWidth-1:0]   digit_char;
  logic                            last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> rtl/rdc_cfg_if.sv
// Configuration write channel carrying the radix register.
interface rdc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rdc_pkg::RadixWidth-1:0]   radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

>>> rtl/rdc_divider.sv
// Bit-serial restoring divider by a small radix, one quotient bit per cycle.
module rdc_divider #(
  parameter int VALUE_BITS = rdc_pkg::DefValueBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rdc_pkg::div_ctrl_t                ctrl_i,
  input  logic [VALUE_BITS-1:0]             dividend_i,
  input  logic [rdc_pkg::RadixWidth-1:0]    radix_i,
  output rdc_pkg::div_stat_t                stat_o
);

  localparam int CntW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0]           quo_q, quo_d;
  logic [rdc_pkg::DigitWidth-1:0]  rem_q, rem_d;
  logic                            nz_q, nz_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [rdc_pkg::RadixWidth-1:0]  trial;
  logic [rdc_pkg::RadixWidth-1:0]  diff;
  logic                            ge;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign ge    = (trial >= radix_i);
  assign diff  = trial - radix_i;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    nz_d   = nz_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.load || ctrl_i.next) begin
      if (ctrl_i.load) begin
        quo_d = dividend_i;
      end
      rem_d  = '0;
      nz_d   = 1'b0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_BITS-2:0], ge};
      rem_d = ge ? diff[rdc_pkg::DigitWidth-1:0] : trial[rdc_pkg::DigitWidth-1:0];
      nz_d  = nz_q | ge;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(VALUE_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    nz_q  <= nz_d;
  end

  assign stat_o.done    = done_q;
  assign stat_o.nonzero = nz_q;
  assign stat_o.rem     = rem_q;

endmodule

>>> rtl/rdc_digit_stack.sv
// Shift-register stack of digits: pushed least significant first, popped in reverse.
module rdc_digit_stack #(
  parameter int MAX_DIGITS = rdc_pkg::DefMaxDigits,
  localparam int CntW      = $clog2(MAX_DIGITS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rdc_pkg::stk_ctrl_t                ctrl_i,
  input  logic [rdc_pkg::DigitWidth-1:0]    digit_i,
  output logic [rdc_pkg::DigitWidth-1:0]    top_o,
  output logic [CntW-1:0]                   count_o
);

  logic [rdc_pkg::DigitWidth-1:0] stk_q [MAX_DIGITS];
  logic [rdc_pkg::DigitWidth-1:0] stk_d [MAX_DIGITS];
  logic [CntW-1:0]                count_q, count_d;

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      stk_d[i] = stk_q[i];
    end
    if (ctrl_i.push) begin
      stk_d[0] = digit_i;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stk_d[i] = stk_q[i-1];
      end
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stk_d[i] = stk_q[i+1];
      end
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      stk_q[i] <= stk_d[i];
    end
  end

  assign top_o   = stk_q[0];
  assign count_o = count_q;

endmodule

>>> rtl/radix_digit_converter.sv
// Top level of the radix digit converter: control, radix register and channels.
//
// Converts one unsigned value per input beat into ASCII digits ('0'-'9', 'A'-'F') in the
// radix held in the configuration register (reset 10; writes below 2 act as 2, above 16
// as 16). Digits leave most significant first, one per output beat, and the least
// significant digit carries last_digit; zero gives the single digit '0'. Only the low
// VALUE_BITS bits of the value are converted, and at most MAX_DIGITS digits (the least
// significant ones) are produced. A single bit-serial divider finds the digits one at a
// time, least significant first, and each is pushed onto a digit stack that the output
// pops. A new value is taken once the last digit of the previous one has been taken.
`include "radix_digit_converter_defines.svh"

module radix_digit_converter #(
  parameter int VALUE_BITS = rdc_pkg::DefValueBits,
  parameter int MAX_DIGITS = rdc_pkg::DefMaxDigits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rdc_cfg_if.sink           cfg_i,
  rdc_value_if.sink         in_i,
  rdc_digit_if.source       out_o
);

  localparam int CntW = $clog2(MAX_DIGITS + 1);

  rdc_pkg::state_e                 state_q, state_d;
  logic [rdc_pkg::RadixWidth-1:0]  radix_q, radix_d;
  rdc_pkg::div_ctrl_t              div_ctrl;
  rdc_pkg::div_stat_t              div_stat;
  rdc_pkg::stk_ctrl_t              stk_ctrl;
  logic [rdc_pkg::DigitWidth-1:0]  stk_top;
  logic [CntW-1:0]                 stk_count;
  logic [VALUE_BITS-1:0]           dividend;

  // Radix register, clamped on write since nothing reads it back.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    radix_d = radix_q;
    if (cfg_i.valid) begin
      if (cfg_i.radix < rdc_pkg::RadixMin) begin
        radix_d = rdc_pkg::RadixMin;
      end else if (cfg_i.radix > rdc_pkg::RadixMax) begin
        radix_d = rdc_pkg::RadixMax;
      end else begin
        radix_d = cfg_i.radix;
      end
    end
  end

  assign dividend = VALUE_BITS'(in_i.value);

  always_comb begin
    state_d       = state_q;
    div_ctrl.load = 1'b0;
    div_ctrl.next = 1'b0;
    stk_ctrl.push = 1'b0;
    stk_ctrl.pop  = 1'b0;
    in_i.ready    = 1'b0;
    out_o.valid   = 1'b0;
    case (state_q)
      rdc_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          div_ctrl.load = 1'b1;
          state_d       = rdc_pkg::StDivide;
        end
      end
      rdc_pkg::StDivide: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          // Keep dividing while the quotient is nonzero and the stack has room.
          if (div_stat.nonzero && (stk_count < CntW'(MAX_DIGITS - 1))) begin
            div_ctrl.next = 1'b1;
          end else begin
            state_d = rdc_pkg::StEmit;
          end
        end
      end
      rdc_pkg::StEmit: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          stk_ctrl.pop = 1'b1;
          if (stk_count == CntW'(1)) begin
            state_d = rdc_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = rdc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdc_pkg::StIdle;
      radix_q <= rdc_pkg::RadixReset;
    end else begin
      state_q <= state_d;
      radix_q <= radix_d;
    end
  end

  rdc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .radix_i    (radix_q),
    .stat_o     (div_stat)
  );

  rdc_digit_stack #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_digit_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .digit_i (div_stat.rem),
    .top_o   (stk_top),
    .count_o (stk_count)
  );

  assign out_o.digit_char = rdc_pkg::digit_to_char(stk_top);
  assign out_o.last_digit = (stk_count == CntW'(1));

  `RDC_ASSERT_IMPLY(a_accept_empty, in_i.valid && in_i.ready, stk_count == '0)
  `RDC_ASSERT_IMPLY(a_done_in_divide, div_stat.done, state_q == rdc_pkg::StDivide)
  `RDC_ASSERT_IMPLY(a_no_overflow, stk_ctrl.push, stk_count < CntW'(MAX_DIGITS))
  `RDC_ASSERT_NEXT(a_last_to_idle, out_o.valid && out_o.ready && out_o.last_digit, state_q == rdc_pkg::StIdle && stk_count == '0)

endmodule

>>> tb/tb_radix_digit_converter.sv
// Self-checking testbench for the radix digit converter top level.
`timescale 1ns / 100ps

module tb_radix_digit_converter;

  localparam int    ClockPeriod    = 10;
  localparam int    ResetCycles    = 11;
  localparam int    CycleLimit     = 4_000_000;
  localparam int    LongHoldCycles = 800;
  localparam int    SettleCycles   = 4;
  localparam int    TailCycles     = 50;
  localparam int    MaxDigits      = rdc_pkg::DefMaxDigits;
  localparam int    ValueWidth     = rdc_pkg::ValueWidth;
  localparam int    RadixWidth     = rdc_pkg::RadixWidth;
  localparam int    CharWidth      = rdc_pkg::CharWidth;
  localparam int    DigitWidth     = rdc_pkg::DigitWidth;
  localparam string DigitGlyphs    = "0123456789ABCDEF";

  typedef struct packed {
    logic [CharWidth-1:0] digit_char;
    logic                 last_digit;
  } digit_beat_t;

  typedef enum int {
    RxAlways,
    RxRandom,
    RxEveryK,
    RxMostly
  } rx_style_e;

  logic clk_i;
  logic rst_ni;

  rdc_cfg_if   cfg_if ();
  rdc_value_if value_if ();
  rdc_digit_if digit_if ();

  radix_digit_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (value_if),
    .out_o  (digit_if)
  );

  logic [RadixWidth-1:0] radix_setting = rdc_pkg::RadixReset;
  digit_beat_t           pending_digits [$];
  int                    mismatch_count = 0;
  int                    burst_left = 0;
  int                    cycle_count = 0;
  bit                    long_hold_pending = 1'b0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #(ClockPeriod / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Expected digits of one value under the current radix, most significant first.
  function automatic void predict_digits(input logic [ValueWidth-1:0] v);
    logic [ValueWidth-1:0] quotient;
    logic [ValueWidth-1:0] base;
    logic [DigitWidth-1:0] remainders [$];
    digit_beat_t           beat;
    quotient = v;
    if (radix_setting < rdc_pkg::RadixMin) begin
      base = ValueWidth'(rdc_pkg::RadixMin);
    end else if (radix_setting > rdc_pkg::RadixMax) begin
      base = ValueWidth'(rdc_pkg::RadixMax);
    end else begin
      base = ValueWidth'(radix_setting);
    end
    do begin
      remainders.push_front(DigitWidth'(quotient % base));
      quotient = quotient / base;
    end while (quotient != 0 && remainders.size() < MaxDigits);
    foreach (remainders[i]) begin
      beat.digit_char = CharWidth'(DigitGlyphs[remainders[i]]);
      beat.last_digit = (i == remainders.size() - 1);
      pending_digits.push_back(beat);
    end
  endfunction

  function automatic logic [ValueWidth-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom() >> $urandom_range(1, 31);
      2: return $urandom_range(0, 300);
      default: return 32'hFFFF_FFFF >> $urandom_range(0, 31);
    endcase
  endfunction

  always @(posedge clk_i) begin : digit_checker
    digit_beat_t want;
    if (rst_ni && digit_if.valid && digit_if.ready) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("digit 0x%0h with none expected", digit_if.digit_char));
      end else begin
        want = pending_digits.pop_front();
        if (digit_if.digit_char !== want.digit_char) begin
          report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
                                    digit_if.digit_char, want.digit_char));
        end
        if (digit_if.last_digit !== want.last_digit) begin
          report_mismatch($sformatf("last_digit %0b, expected %0b",
                                    digit_if.last_digit, want.last_digit));
        end
      end
    end
  end

  // The receiver picks a random stall style for every segment; a requested long hold
  // takes priority and is counted here.
  initial begin : digit_receiver
    int        seg_len;
    int        period;
    rx_style_e style;
    digit_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      seg_len = $urandom_range(20, 200);
      period  = $urandom_range(2, 5);
      style   = rx_style_e'($urandom_range(0, 3));
      for (int c = 0; c < seg_len; c++) begin
        @(negedge clk_i);
        if (long_hold_pending) begin
          long_hold_pending = 1'b0;
          digit_if.ready <= 1'b0;
          repeat (LongHoldCycles) @(negedge clk_i);
        end else begin
          case (style)
            RxAlways: digit_if.ready <= 1'b1;
            RxRandom: digit_if.ready <= 1'($urandom_range(0, 1));
            RxEveryK: digit_if.ready <= (c % period == 0);
            default:  digit_if.ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Sends one value; valid stays high between beats of a burst.
  task automatic send_value(input logic [ValueWidth-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        value_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    value_if.valid <= 1'b1;
    value_if.value <= v;
    do @(posedge clk_i); while (!value_if.ready);
    predict_digits(v);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    value_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drain();
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_radix(input logic [RadixWidth-1:0] r);
    cfg_if.valid <= 1'b1;
    cfg_if.radix <= r;
    do @(posedge clk_i); while (!cfg_if.ready);
    radix_setting = r;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Runs with the radix left at its reset value.
  task automatic test_reset_radix();
    send_value(0);
    send_value(7);
    send_value(10);
    send_value(1_000_000_000);
    send_value(32'hFFFF_FFFF);
    end_burst();
    wait_drain();
  endtask

  // Binary gives the longest digit strings, up to 32 beats for one value.
  task automatic test_binary_extremes();
    write_radix(RadixWidth'(2));
    send_value(0);
    send_value(1);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    end_burst();
    wait_drain();
  endtask

  task automatic test_hex_glyphs();
    write_radix(RadixWidth'(16));
    send_value(32'h0000_000F);
    send_value(32'hABCD_EF01);
    send_value(32'hFFFF_FFFF);
    end_burst();
    wait_drain();
  endtask

  // Register values outside 2..16 must act as the nearest bound.
  task automatic test_radix_clamp();
    write_radix(RadixWidth'(0));
    send_value(5);
    end_burst();
    wait_drain();
    write_radix(RadixWidth'(1));
    send_value(6);
    end_burst();
    wait_drain();
    write_radix(RadixWidth'(17));
    send_value(255);
    end_burst();
    wait_drain();
    write_radix(RadixWidth'(31));
    send_value(32'hFFFF_FFFF);
    end_burst();
    wait_drain();
  endtask

  // The output is held off long enough that the converter stops taking values.
  task automatic test_output_hold_off();
    write_radix(RadixWidth'(10));
    long_hold_pending = 1'b1;
    burst_left = 100;
    repeat (6) send_value(32'd3_000_000_000 + $urandom_range(0, 1_000_000_000));
    end_burst();
    wait_drain();
  endtask

  task automatic test_random_values();
    int radix_plan [] = '{2, 3, 5, 8, 10, 11, 13, 16, 0, 0, 0};
    foreach (radix_plan[i]) begin
      write_radix((i >= 8) ? RadixWidth'($urandom_range(0, 31)) : RadixWidth'(radix_plan[i]));
      repeat (18) send_value(random_value());
      end_burst();
      wait_drain();
    end
  endtask

  initial begin : test_sequence
    rst_ni         = 1'b0;
    value_if.valid = 1'b0;
    value_if.value = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.radix   = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_radix();
    test_binary_extremes();
    test_hex_glyphs();
    test_radix_clamp();
    test_output_hold_off();
    test_random_values();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
